/* rtl/sbv_pkg.sv */
package sbv_pkg;

  // Angle format and quarter-turn geometry.
  localparam int unsigned ANGLE_W         = 16;
  localparam int unsigned ANGLE_FRAC_BITS = 7;
  localparam int unsigned QUARTER_ODD     = 45;
  localparam int unsigned QUARTER_POW     = ANGLE_FRAC_BITS + 1;
  localparam int unsigned QUARTER         = QUARTER_ODD << QUARTER_POW;
  localparam int unsigned FULL_TURN       = 4 * QUARTER;
  localparam int unsigned F_W             = $clog2(QUARTER);
  localparam int unsigned A_W             = QUARTER_POW;
  localparam int unsigned B_W             = $clog2(QUARTER_ODD);

  // Fixed-point formats.
  localparam int unsigned Q_FRAC        = 30;
  localparam int unsigned OUT_FRAC_BITS = 15;
  localparam int unsigned OUT_W         = 16;
  localparam int unsigned FRAC_SHIFT    = Q_FRAC - QUARTER_POW;
  localparam int unsigned T_W           = Q_FRAC;
  localparam int unsigned X_W           = Q_FRAC + 1;
  localparam int unsigned X2_W          = X_W + 1;
  localparam int unsigned N_W           = X2_W;
  localparam int unsigned TERM_W        = X_W;
  localparam int unsigned ACC_W         = TERM_W + 3;
  localparam int unsigned PROD_W        = N_W + Q_FRAC;
  localparam int unsigned SC_W          = Q_FRAC + 2;
  localparam int unsigned MAG_W         = Q_FRAC + 1;

  // Reciprocal for the offset split by the odd factor of a quarter turn.
  localparam int unsigned DIV_SHIFT = 16;
  localparam int unsigned DIV_RECIP = (1 << DIV_SHIFT) / QUARTER_ODD;
  localparam int unsigned RECIP_W   = $clog2(DIV_RECIP + 1);

  localparam logic [X_W-1:0] HALF_PI_Q30 = 31'd1686629713;
  localparam int unsigned    HP_SPLIT    = 16;
  localparam logic [TERM_W-1:0] ONE_Q30  = TERM_W'(64'd1 << Q_FRAC);

  localparam int unsigned NUM_CELLS = 8;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] polar_angle;
    logic [ANGLE_W-1:0] azimuth_angle;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] phi_vec_x;
    logic signed [OUT_W-1:0] phi_vec_y;
    logic signed [OUT_W-1:0] theta_vec_x;
    logic signed [OUT_W-1:0] theta_vec_y;
    logic signed [OUT_W-1:0] theta_vec_z;
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
  } out_t;

  // Reduced angle: quadrant, radian offset and its square, all Q30.
  typedef struct packed {
    quad_t           quad;
    logic [X_W-1:0]  x;
    logic [X2_W-1:0] x2;
  } red_t;

  // Data handed from one series cell to the next.
  typedef struct packed {
    quad_t                    quad;
    logic [X2_W-1:0]          x2;
    logic [TERM_W-1:0]        sin_term;
    logic signed [ACC_W-1:0]  sin_acc;
    logic [TERM_W-1:0]        cos_term;
    logic signed [ACC_W-1:0]  cos_acc;
  } cell_t;

endpackage

/* rtl/sbv_reduce.sv */
module sbv_reduce
  import sbv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [ANGLE_W-1:0] in_angle,
  output logic               out_vld,
  output red_t               out_red
);

  localparam int unsigned DEPTH = 8;
  localparam int unsigned B0_W  = B_W + 1;
  localparam int unsigned PH_W  = T_W + X_W - HP_SPLIT;
  localparam int unsigned PL_W  = T_W + HP_SPLIT;
  localparam int unsigned SUM_W = T_W + X_W;

  typedef logic [FRAC_SHIFT-1:0] lut_t [QUARTER_ODD];

  function automatic lut_t build_lut();
    lut_t tab;
    for (int i = 0; i < QUARTER_ODD; i++) begin
      tab[i] = FRAC_SHIFT'((64'(i) << FRAC_SHIFT) / QUARTER_ODD);
    end
    return tab;
  endfunction

  // Fraction of a quarter turn for each remainder of the odd factor.
  localparam lut_t FRAC_LUT = build_lut();

  localparam logic [X_W-HP_SPLIT-1:0] HP_HI = HALF_PI_Q30[X_W-1:HP_SPLIT];
  localparam logic [HP_SPLIT-1:0]     HP_LO = HALF_PI_Q30[HP_SPLIT-1:0];

  logic [DEPTH-1:0]   vld_r;

  logic [ANGLE_W-1:0] r1_r, r1_nxt;
  quad_t              q2_r, q2_nxt;
  logic [F_W-1:0]     f2_r, f2_nxt;
  quad_t              q3_r;
  logic [F_W-1:0]     f3_r;
  logic [A_W-1:0]     a3_r, a3_nxt;
  quad_t              q4_r;
  logic [A_W-1:0]     a4_r, a4_nxt;
  logic [B_W-1:0]     b4_r, b4_nxt;
  quad_t              q5_r;
  logic [T_W-1:0]     t5_r, t5_nxt;
  quad_t              q6_r;
  logic [PH_W-1:0]    ph6_r, ph6_nxt;
  logic [PL_W-1:0]    pl6_r, pl6_nxt;
  quad_t              q7_r;
  logic [X_W-1:0]     x7_r, x7_nxt;
  quad_t              q8_r;
  logic [X_W-1:0]     x8_r;
  logic [X2_W-1:0]    x28_r, x28_nxt;

  logic [F_W-1:0]     odd_prod;
  logic [B0_W-1:0]    b0;
  logic [SUM_W-1:0]   sum;

  always_comb begin
    r1_nxt = (in_angle >= ANGLE_W'(FULL_TURN)) ? in_angle - ANGLE_W'(FULL_TURN) : in_angle;

    if (r1_r >= ANGLE_W'(3 * QUARTER)) begin
      q2_nxt = QUAD_3;
      f2_nxt = F_W'(r1_r - ANGLE_W'(3 * QUARTER));
    end else if (r1_r >= ANGLE_W'(2 * QUARTER)) begin
      q2_nxt = QUAD_2;
      f2_nxt = F_W'(r1_r - ANGLE_W'(2 * QUARTER));
    end else if (r1_r >= ANGLE_W'(QUARTER)) begin
      q2_nxt = QUAD_1;
      f2_nxt = F_W'(r1_r - ANGLE_W'(QUARTER));
    end else begin
      q2_nxt = QUAD_0;
      f2_nxt = F_W'(r1_r);
    end

    // The reciprocal runs low, so the estimate is exact or one short.
    a3_nxt = A_W'(((F_W + RECIP_W)'(f2_r) * (F_W + RECIP_W)'(DIV_RECIP)) >> DIV_SHIFT);

    odd_prod = F_W'(F_W'(a3_r) * F_W'(QUARTER_ODD));
    b0       = B0_W'(f3_r - odd_prod);
    if (b0 >= B0_W'(QUARTER_ODD)) begin
      a4_nxt = a3_r + A_W'(1);
      b4_nxt = B_W'(b0 - B0_W'(QUARTER_ODD));
    end else begin
      a4_nxt = a3_r;
      b4_nxt = B_W'(b0);
    end

    t5_nxt = {a4_r, FRAC_LUT[b4_r]};

    ph6_nxt = PH_W'(t5_r) * PH_W'(HP_HI);
    pl6_nxt = PL_W'(t5_r) * PL_W'(HP_LO);

    sum    = (SUM_W'(ph6_r) << HP_SPLIT) + SUM_W'(pl6_r);
    x7_nxt = X_W'(sum >> Q_FRAC);

    x28_nxt = X2_W'(((2 * X_W)'(x7_r) * (2 * X_W)'(x7_r)) >> Q_FRAC);
  end

  always_ff @(posedge clk) begin
    r1_r  <= r1_nxt;
    q2_r  <= q2_nxt;
    f2_r  <= f2_nxt;
    q3_r  <= q2_r;
    f3_r  <= f2_r;
    a3_r  <= a3_nxt;
    q4_r  <= q3_r;
    a4_r  <= a4_nxt;
    b4_r  <= b4_nxt;
    q5_r  <= q4_r;
    t5_r  <= t5_nxt;
    q6_r  <= q5_r;
    ph6_r <= ph6_nxt;
    pl6_r <= pl6_nxt;
    q7_r  <= q6_r;
    x7_r  <= x7_nxt;
    q8_r  <= q7_r;
    x8_r  <= x7_r;
    x28_r <= x28_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DEPTH-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[DEPTH-1];
  assign out_red = '{quad: q8_r, x: x8_r, x2: x28_r};

endmodule

/* rtl/sbv_cell.sv */
module sbv_cell
  import sbv_pkg::*;
#(
  parameter int unsigned INDEX = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_vld,
  input  cell_t in_cell,
  output logic  out_vld,
  output cell_t out_cell
);

  localparam int unsigned COS_DIV   = (2 * INDEX + 1) * (2 * INDEX + 2);
  localparam int unsigned SIN_DIV   = (2 * INDEX + 2) * (2 * INDEX + 3);
  localparam int unsigned COS_SH    = N_W - 1 + $clog2(COS_DIV);
  localparam int unsigned SIN_SH    = N_W - 1 + $clog2(SIN_DIV);
  localparam logic [N_W-1:0] COS_RECIP = N_W'((64'd1 << COS_SH) / COS_DIV);
  localparam logic [N_W-1:0] SIN_RECIP = N_W'((64'd1 << SIN_SH) / SIN_DIV);
  localparam bit SUB_TERM = (INDEX % 2) == 1;
  localparam int unsigned R_W = N_W + 2;

  typedef struct packed {
    quad_t                   quad;
    logic [X2_W-1:0]         x2;
    logic signed [ACC_W-1:0] sin_acc;
    logic signed [ACC_W-1:0] cos_acc;
    logic [PROD_W-1:0]       sin_prod;
    logic [PROD_W-1:0]       cos_prod;
  } st1_t;

  typedef struct packed {
    quad_t                   quad;
    logic [X2_W-1:0]         x2;
    logic signed [ACC_W-1:0] sin_acc;
    logic signed [ACC_W-1:0] cos_acc;
    logic [N_W-1:0]          sin_n;
    logic [N_W-1:0]          cos_n;
    logic [2*N_W-1:0]        sin_qm;
    logic [2*N_W-1:0]        cos_qm;
  } st2_t;

  logic [2:0] vld_r;
  st1_t       s1_r, s1_nxt;
  st2_t       s2_r, s2_nxt;
  cell_t      s3_r, s3_nxt;

  logic signed [ACC_W-1:0] sin_step, cos_step;
  logic [N_W-1:0]          sin_q0, cos_q0;
  logic [R_W-1:0]          sin_rem, cos_rem;

  always_comb begin
    // The term that arrives is folded into the sum while the next one is formed.
    sin_step = $signed(ACC_W'(in_cell.sin_term));
    cos_step = $signed(ACC_W'(in_cell.cos_term));
    s1_nxt.quad     = in_cell.quad;
    s1_nxt.x2       = in_cell.x2;
    s1_nxt.sin_acc  = SUB_TERM ? in_cell.sin_acc - sin_step : in_cell.sin_acc + sin_step;
    s1_nxt.cos_acc  = SUB_TERM ? in_cell.cos_acc - cos_step : in_cell.cos_acc + cos_step;
    s1_nxt.sin_prod = PROD_W'(in_cell.sin_term) * PROD_W'(in_cell.x2);
    s1_nxt.cos_prod = PROD_W'(in_cell.cos_term) * PROD_W'(in_cell.x2);

    s2_nxt.quad    = s1_r.quad;
    s2_nxt.x2      = s1_r.x2;
    s2_nxt.sin_acc = s1_r.sin_acc;
    s2_nxt.cos_acc = s1_r.cos_acc;
    s2_nxt.sin_n   = N_W'(s1_r.sin_prod >> Q_FRAC);
    s2_nxt.cos_n   = N_W'(s1_r.cos_prod >> Q_FRAC);
    s2_nxt.sin_qm  = (2 * N_W)'(N_W'(s1_r.sin_prod >> Q_FRAC)) * (2 * N_W)'(SIN_RECIP);
    s2_nxt.cos_qm  = (2 * N_W)'(N_W'(s1_r.cos_prod >> Q_FRAC)) * (2 * N_W)'(COS_RECIP);

    // The truncated reciprocal leaves the quotient exact or one short.
    sin_q0  = N_W'(s2_r.sin_qm >> SIN_SH);
    cos_q0  = N_W'(s2_r.cos_qm >> COS_SH);
    sin_rem = R_W'(s2_r.sin_n) - R_W'(R_W'(sin_q0) * R_W'(SIN_DIV));
    cos_rem = R_W'(s2_r.cos_n) - R_W'(R_W'(cos_q0) * R_W'(COS_DIV));

    s3_nxt.quad     = s2_r.quad;
    s3_nxt.x2       = s2_r.x2;
    s3_nxt.sin_acc  = s2_r.sin_acc;
    s3_nxt.cos_acc  = s2_r.cos_acc;
    s3_nxt.sin_term = (sin_rem >= R_W'(SIN_DIV)) ? TERM_W'(sin_q0 + N_W'(1)) : TERM_W'(sin_q0);
    s3_nxt.cos_term = (cos_rem >= R_W'(COS_DIV)) ? TERM_W'(cos_q0 + N_W'(1)) : TERM_W'(cos_q0);
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  assign out_vld  = vld_r[2];
  assign out_cell = s3_r;

endmodule

/* rtl/sbv_sincos.sv */
module sbv_sincos
  import sbv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [ANGLE_W-1:0]     in_angle,
  output logic                   out_vld,
  output logic signed [SC_W-1:0] out_sin,
  output logic signed [SC_W-1:0] out_cos
);

  localparam logic signed [ACC_W-1:0] ONE_ACC = ACC_W'(ONE_Q30);

  logic                 red_vld;
  red_t                 red;
  logic [NUM_CELLS:0]   link_vld;
  cell_t                link [NUM_CELLS+1];

  logic [1:0]              vld_r;
  quad_t                   q1_r;
  logic [TERM_W-1:0]       ps1_r, ps1_nxt;
  logic [TERM_W-1:0]       pc1_r, pc1_nxt;
  logic signed [SC_W-1:0]  sin_r, sin_nxt;
  logic signed [SC_W-1:0]  cos_r, cos_nxt;
  logic signed [ACC_W-1:0] sin_sum, cos_sum;
  logic signed [SC_W-1:0]  ps_s, pc_s;

  sbv_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .in_angle (in_angle),
    .out_vld  (red_vld),
    .out_red  (red)
  );

  assign link_vld[0] = red_vld;
  assign link[0] = '{
    quad:     red.quad,
    x2:       red.x2,
    sin_term: TERM_W'(red.x),
    sin_acc:  '0,
    cos_term: ONE_Q30,
    cos_acc:  '0
  };

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    sbv_cell #(
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (link_vld[i]),
      .in_cell  (link[i]),
      .out_vld  (link_vld[i+1]),
      .out_cell (link[i+1])
    );
  end

  always_comb begin
    // The last term of the chain still has to be added, then the sum is clamped.
    sin_sum = link[NUM_CELLS].sin_acc + $signed(ACC_W'(link[NUM_CELLS].sin_term));
    cos_sum = link[NUM_CELLS].cos_acc + $signed(ACC_W'(link[NUM_CELLS].cos_term));

    if (sin_sum < 0) begin
      ps1_nxt = '0;
    end else if (sin_sum > ONE_ACC) begin
      ps1_nxt = ONE_Q30;
    end else begin
      ps1_nxt = TERM_W'(sin_sum);
    end

    if (cos_sum < 0) begin
      pc1_nxt = '0;
    end else if (cos_sum > ONE_ACC) begin
      pc1_nxt = ONE_Q30;
    end else begin
      pc1_nxt = TERM_W'(cos_sum);
    end

    ps_s = $signed(SC_W'(ps1_r));
    pc_s = $signed(SC_W'(pc1_r));
    case (q1_r)
      QUAD_0: begin
        sin_nxt = ps_s;
        cos_nxt = pc_s;
      end
      QUAD_1: begin
        sin_nxt = pc_s;
        cos_nxt = -ps_s;
      end
      QUAD_2: begin
        sin_nxt = -ps_s;
        cos_nxt = -pc_s;
      end
      default: begin
        sin_nxt = -pc_s;
        cos_nxt = ps_s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q1_r  <= link[NUM_CELLS].quad;
    ps1_r <= ps1_nxt;
    pc1_r <= pc1_nxt;
    sin_r <= sin_nxt;
    cos_r <= cos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[0], link_vld[NUM_CELLS]};
    end
  end

  assign out_vld = vld_r[1];
  assign out_sin = sin_r;
  assign out_cos = cos_r;

endmodule

/* rtl/spherical_basis_vectors_unit.sv */
// Spherical unit vectors from a polar angle and an azimuth.
// Input: raise start with in_data (polar and azimuth angle, degrees with seven
// fraction bits); a beat is taken at every rising edge where start is high and
// busy is low. busy stays low, so a new angle pair can enter on every cycle.
// Output: out_valid is high for exactly one cycle with out_data, which carries
// the phi vector (x, y), the theta vector (x, y, z) and the inward normal
// (x, y, z), all signed Q1.15. Results leave in the order the beats came in.
// Throughput is one result per cycle. The path from input to output is the
// angle reduction front end (8 stages), eight series cells of 3 stages each
// that build sine and cosine, 2 stages of clamping and quadrant mapping, and
// 4 stages of products, rounding and output saturation.
// Reset (rst_n low, synchronous) drops every beat in flight; no result is
// shown for them. There is no way to stall the output: a result is presented
// once and must be taken in that cycle.
module spherical_basis_vectors_unit
  import sbv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int unsigned P_W      = 2 * MAG_W;
  localparam int unsigned ROUND_SH = Q_FRAC - OUT_FRAC_BITS;
  localparam int unsigned M_W      = MAG_W - ROUND_SH + 1;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sm_t;

  typedef struct packed {
    logic           neg;
    logic [P_W-1:0] prod;
  } sp_t;

  function automatic sm_t to_sm(input logic signed [SC_W-1:0] v);
    sm_t r;
    r.neg = v[SC_W-1];
    r.mag = r.neg ? MAG_W'(-v) : MAG_W'(v);
    return r;
  endfunction

  function automatic sm_t round_prod(input sp_t p);
    sm_t r;
    r.neg = p.neg;
    r.mag = MAG_W'((p.prod + (P_W'(1) << (Q_FRAC - 1))) >> Q_FRAC);
    return r;
  endfunction

  // Round the magnitude half away from zero, saturate it, then apply the sign.
  function automatic logic signed [OUT_W-1:0] to_out(input sm_t v);
    logic [M_W-1:0] m;
    m = M_W'((M_W + ROUND_SH)'(v.mag) + (M_W + ROUND_SH)'(1 << (ROUND_SH - 1)) >> ROUND_SH);
    if (v.neg) begin
      if (m > M_W'(1 << OUT_FRAC_BITS)) begin
        m = M_W'(1 << OUT_FRAC_BITS);
      end
      return OUT_W'(-m);
    end else begin
      if (m > M_W'((1 << OUT_FRAC_BITS) - 1)) begin
        m = M_W'((1 << OUT_FRAC_BITS) - 1);
      end
      return OUT_W'(m);
    end
  endfunction

  logic                   take;
  logic                   theta_vld, phi_vld;
  logic signed [SC_W-1:0] st, ct, sp, cp;

  logic [3:0] vld_r;
  sm_t        st1_r, ct1_r, sp1_r, cp1_r;
  sm_t        st2_r, ct2_r, sp2_r, cp2_r;
  sp_t        ctcp2_r, ctsp2_r, stcp2_r, stsp2_r;
  sm_t        st3_r, ct3_r, sp3_r, cp3_r;
  sm_t        ctcp3_r, ctsp3_r, stcp3_r, stsp3_r;
  out_t       out_r, out_nxt;

  assign busy = 1'b0;
  assign take = start & ~busy;

  sbv_sincos u_theta (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (take),
    .in_angle (in_data.polar_angle),
    .out_vld  (theta_vld),
    .out_sin  (st),
    .out_cos  (ct)
  );

  sbv_sincos u_phi (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (take),
    .in_angle (in_data.azimuth_angle),
    .out_vld  (phi_vld),
    .out_sin  (sp),
    .out_cos  (cp)
  );

  always_comb begin
    out_nxt.phi_vec_x   = to_out('{neg: ~sp3_r.neg, mag: sp3_r.mag});
    out_nxt.phi_vec_y   = to_out(cp3_r);
    out_nxt.theta_vec_x = to_out(ctcp3_r);
    out_nxt.theta_vec_y = to_out(ctsp3_r);
    out_nxt.theta_vec_z = to_out('{neg: ~st3_r.neg, mag: st3_r.mag});
    out_nxt.normal_x    = to_out('{neg: ~stcp3_r.neg, mag: stcp3_r.mag});
    out_nxt.normal_y    = to_out('{neg: ~stsp3_r.neg, mag: stsp3_r.mag});
    out_nxt.normal_z    = to_out('{neg: ~ct3_r.neg, mag: ct3_r.mag});
  end

  always_ff @(posedge clk) begin
    st1_r <= to_sm(st);
    ct1_r <= to_sm(ct);
    sp1_r <= to_sm(sp);
    cp1_r <= to_sm(cp);

    st2_r   <= st1_r;
    ct2_r   <= ct1_r;
    sp2_r   <= sp1_r;
    cp2_r   <= cp1_r;
    ctcp2_r <= '{neg: ct1_r.neg ^ cp1_r.neg, prod: P_W'(ct1_r.mag) * P_W'(cp1_r.mag)};
    ctsp2_r <= '{neg: ct1_r.neg ^ sp1_r.neg, prod: P_W'(ct1_r.mag) * P_W'(sp1_r.mag)};
    stcp2_r <= '{neg: st1_r.neg ^ cp1_r.neg, prod: P_W'(st1_r.mag) * P_W'(cp1_r.mag)};
    stsp2_r <= '{neg: st1_r.neg ^ sp1_r.neg, prod: P_W'(st1_r.mag) * P_W'(sp1_r.mag)};

    st3_r   <= st2_r;
    ct3_r   <= ct2_r;
    sp3_r   <= sp2_r;
    cp3_r   <= cp2_r;
    ctcp3_r <= round_prod(ctcp2_r);
    ctsp3_r <= round_prod(ctsp2_r);
    stcp3_r <= round_prod(stcp2_r);
    stsp3_r <= round_prod(stsp2_r);

    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], theta_vld & phi_vld};
    end
  end

  assign out_valid = vld_r[3];
  assign out_data  = out_r;

endmodule
